>>> design/ppsc_pkg.sv
// ----------------------------------------------------------------------------
// ppsc_pkg - shared constants for the pluto position series core
// fixed-point formats, polynomial and series coefficients, divisors
// ----------------------------------------------------------------------------
package ppsc_pkg;

  // phase and trig formats
  localparam int unsigned PH_W   = 32;  // phase, q0.32 turns
  localparam int unsigned U_W    = 30;  // folded octant angle, q0.32 turns
  localparam int unsigned Z_W    = 27;  // u*u >> 32
  localparam int unsigned ACC_W  = 35;  // horner accumulator, q.28
  localparam int unsigned TRIG_W = 30;  // signed sin/cos, q.28
  localparam int unsigned NPOLY  = 5;   // horner cells per polynomial

  // series sums and division
  localparam int unsigned K_W    = 28;  // signed series coefficient
  localparam int unsigned PROD_W = TRIG_W + K_W;
  localparam int unsigned TL_W   = 60;  // t * 144960000
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 28;
  localparam int unsigned Q_W    = 31;
  localparam int unsigned RES_W  = 32;
  localparam int unsigned NTRIG  = 6;   // s1 c1 s2 c2 s3 c3
  localparam int unsigned NOUT   = 3;   // longitude, latitude, radius

  // reciprocal division: both divisors carry a 2^9 factor, the rest is
  // divided by a 32-bit reciprocal whose estimate is low by at most one
  localparam int unsigned DIV_PRE = 9;
  localparam int unsigned X_W     = 50;  // magnitude >> 9, unsaturated span
  localparam int unsigned XH_W    = 25;  // split of x for the partial products
  localparam int unsigned RCP_W   = 32;
  localparam int unsigned PP_W    = XH_W + RCP_W;
  localparam int unsigned DVS_W   = 19;  // divisor >> 9
  localparam int unsigned SH_W    = 6;

  // pipeline depths
  localparam int unsigned LANE_LAT = 8;
  localparam int unsigned DIV_LAT  = 6;
  localparam int unsigned TL_DLY   = LANE_LAT + 3;
  localparam int unsigned PIPE_LAT = 2 + LANE_LAT + 4 + DIV_LAT;

  // phase generation
  localparam logic signed [31:0] PH_RATE = 32'sd1729440165;
  localparam logic [PH_W-1:0]    PH_OFF  = 32'd2850903847;
  localparam logic signed [31:0] LON_RATE = 32'sd144960000;

  // octant polynomials, start value then one coefficient per cell
  localparam logic [ACC_W-1:0] SIN_START = 35'd20590572441 + 35'd0 - 35'd9300527753;
  localparam logic [ACC_W-1:0] COS_START = 35'd7093744290;
  localparam logic [ACC_W-1:0] SIN_COEF [NPOLY] = '{
    35'd20590572441, 35'd21905742301, 35'd11097578693, 35'd1686629713, 35'd0
  };
  localparam logic [ACC_W-1:0] COS_COEF [NPOLY] = '{
    35'd16171797778, 35'd22939639695, 35'd17432035847, 35'd5298703516, 35'd268435456
  };

  // series weights, order s1 c1 s2 c2 s3 c3
  localparam logic signed [K_W-1:0] SER_K [NOUT][NTRIG] = '{
    '{-28'sd19798886,  28'sd19848454,   28'sd897499, -28'sd4955707,
       28'sd0,          28'sd0},
    '{-28'sd5453098,  -28'sd14974876,  28'sd3527363,  28'sd1672673,
      -28'sd1050939,    28'sd327763},
    '{ 28'sd66867334,  28'sd68955876, -28'sd11826086, -28'sd333765,
       28'sd1593657,  -28'sd1439953}
  };

  // constant offsets scaled by 2^28
  localparam logic signed [NUM_W-1:0] SER_OFF [NOUT] = '{
    64'sd238956785 * 64'sd268435456,
    -64'sd3908202  * 64'sd268435456,
    64'sd407247248 * 64'sd268435456
  };

  localparam logic [DEN_W-1:0] SER_DEN [NOUT] = '{
    28'd64000000, 28'd64000000, 28'd160000000
  };

  // divisor >> 9, floor(2^sh / that), and sh
  localparam logic [DVS_W-1:0] DIV_DVS [NOUT] = '{
    19'd125000, 19'd125000, 19'd312500
  };
  localparam logic [RCP_W-1:0] DIV_RCP [NOUT] = '{
    32'd2251799813, 32'd2251799813, 32'd3602879701
  };
  localparam logic [SH_W-1:0] DIV_SH [NOUT] = '{
    6'd48, 6'd48, 6'd50
  };

endpackage

>>> design/ppsc_poly_cell.sv
// ----------------------------------------------------------------------------
// ppsc_poly_cell - one horner step of an octant polynomial
// acc_out = coef -/+ ((acc_in * mul_in) >> 32), registered
// ----------------------------------------------------------------------------
module ppsc_poly_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppsc_pkg::ACC_W-1:0]  acc_in,
  input  logic [ppsc_pkg::U_W-1:0]    mul_in,
  input  logic [ppsc_pkg::ACC_W-1:0]  coef,
  input  logic                        sub,
  output logic [ppsc_pkg::ACC_W-1:0]  acc_out
);
  import ppsc_pkg::*;

  logic [ACC_W+U_W-1:0] prod;
  logic [ACC_W-1:0]     term;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]     acc_nxt;

  always_comb begin
    prod    = (ACC_W+U_W)'(acc_in) * (ACC_W+U_W)'(mul_in);
    term    = ACC_W'(prod[ACC_W+U_W-1:32]);
    acc_nxt = sub ? (coef - term) : (coef + term);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_out = acc_r;

endmodule

>>> design/ppsc_sincos_lane.sv
// ----------------------------------------------------------------------------
// ppsc_sincos_lane - sine and cosine of a phase in turns
// octant fold, square, two rows of horner cells, quadrant unfold
// ----------------------------------------------------------------------------
module ppsc_sincos_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ppsc_pkg::PH_W-1:0]          ph,
  output logic signed [ppsc_pkg::TRIG_W-1:0] sn,
  output logic signed [ppsc_pkg::TRIG_W-1:0] cs
);
  import ppsc_pkg::*;

  logic [U_W-1:0]  r;
  logic            swap;
  logic [U_W-1:0]  u;
  logic [U_W-1:0]  u_a_r;
  logic [1:0]      quad_a_r;
  logic            swap_a_r;
  logic [2*U_W-1:0] sq;

  logic [U_W-1:0]  zd_r [NPOLY];
  logic [U_W-1:0]  ud_r [NPOLY];
  logic [1:0]      qd_r [NPOLY+1];
  logic            sd_r [NPOLY+1];

  logic [ACC_W-1:0] sin_acc [NPOLY];
  logic [ACC_W-1:0] cos_acc [NPOLY];

  logic signed [TRIG_W-1:0] so, co, a, b;
  logic signed [TRIG_W-1:0] sn_r, cs_r, sn_nxt, cs_nxt;

  // fold to one octant
  always_comb begin
    r    = ph[U_W-1:0];
    swap = (r > U_W'(32'd536870912));
    u    = swap ? U_W'(31'd1073741824 - 31'(r)) : r;
    sq   = (2*U_W)'(u_a_r) * (2*U_W)'(u_a_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_a_r    <= u;
      quad_a_r <= ph[PH_W-1:PH_W-2];
      swap_a_r <= swap;
      zd_r[0]  <= U_W'(sq[Z_W+31:32]);
      ud_r[0]  <= u_a_r;
      qd_r[0]  <= quad_a_r;
      sd_r[0]  <= swap_a_r;
      for (int k = 1; k < NPOLY; k++) begin
        zd_r[k] <= zd_r[k-1];
        ud_r[k] <= ud_r[k-1];
      end
      for (int k = 1; k <= NPOLY; k++) begin
        qd_r[k] <= qd_r[k-1];
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < NPOLY; k++) begin : g_cell
    ppsc_poly_cell u_sin (
      .clk     (clk),
      .en      (en),
      .acc_in  ((k == 0) ? SIN_START : sin_acc[(k == 0) ? 0 : k-1]),
      .mul_in  ((k == NPOLY-1) ? ud_r[k] : zd_r[k]),
      .coef    (SIN_COEF[k]),
      .sub     (k != NPOLY-1),
      .acc_out (sin_acc[k])
    );
    ppsc_poly_cell u_cos (
      .clk     (clk),
      .en      (en),
      .acc_in  ((k == 0) ? COS_START : cos_acc[(k == 0) ? 0 : k-1]),
      .mul_in  (zd_r[k]),
      .coef    (COS_COEF[k]),
      .sub     (1'b1),
      .acc_out (cos_acc[k])
    );
  end

  // undo octant and quadrant folding
  always_comb begin
    so = signed'(TRIG_W'(sin_acc[NPOLY-1]));
    co = signed'(TRIG_W'(cos_acc[NPOLY-1]));
    a  = sd_r[NPOLY] ? co : so;
    b  = sd_r[NPOLY] ? so : co;
    unique case (qd_r[NPOLY])
      2'd0:    begin sn_nxt = a;  cs_nxt = b;  end
      2'd1:    begin sn_nxt = b;  cs_nxt = -a; end
      2'd2:    begin sn_nxt = -a; cs_nxt = -b; end
      default: begin sn_nxt = -b; cs_nxt = a;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= sn_nxt;
      cs_r <= cs_nxt;
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule

>>> design/ppsc_div_cell.sv
// ----------------------------------------------------------------------------
// ppsc_div_cell - correction step of a reciprocal division
// bumps the quotient estimate when the remainder reaches the divisor
// ----------------------------------------------------------------------------
module ppsc_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppsc_pkg::X_W-1:0]    rem_in,
  input  logic [ppsc_pkg::Q_W-1:0]    q_in,
  input  logic [ppsc_pkg::DVS_W-1:0]  dvs,
  output logic [ppsc_pkg::Q_W-1:0]    q_out
);
  import ppsc_pkg::*;

  logic           ge;
  logic [Q_W-1:0] q_r, q_nxt;

  always_comb begin
    ge    = (rem_in >= X_W'(dvs));
    q_nxt = q_in + Q_W'(ge);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

>>> design/ppsc_div_lane.sv
// ----------------------------------------------------------------------------
// ppsc_div_lane - saturated division by a constant, rounding offset added by the caller
// overflow check, reciprocal multiply, one correction step, sign and saturation
// ----------------------------------------------------------------------------
module ppsc_div_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppsc_pkg::NUM_W-1:0]  mag,
  input  logic                        neg,
  input  logic [ppsc_pkg::DVS_W-1:0]  dvs,
  input  logic [ppsc_pkg::RCP_W-1:0]  rcp,
  input  logic [ppsc_pkg::SH_W-1:0]   sh,
  output logic [ppsc_pkg::RES_W-1:0]  res
);
  import ppsc_pkg::*;

  logic [NUM_W-1:0]       lim;
  logic [X_W-1:0]         x_r [DIV_LAT-2];
  logic [PP_W-1:0]        pp_hi_r, pp_lo_r;
  logic [X_W+RCP_W-1:0]   pp_sum;
  logic [Q_W-1:0]         qe_r, q4_r, q5;
  logic [X_W-1:0]         qd_r;
  logic [X_W-1:0]         rem;
  logic                   sat_r [DIV_LAT-1];
  logic                   neg_r [DIV_LAT-1];
  logic [RES_W-1:0]       res_r, res_nxt;

  // quotient of 2^31 or more saturates
  assign lim = NUM_W'({dvs, (Q_W+DIV_PRE)'(0)});

  always_comb begin
    pp_sum = ((X_W+RCP_W)'(pp_hi_r) << XH_W) + (X_W+RCP_W)'(pp_lo_r);
    rem    = x_r[DIV_LAT-3] - qd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= X_W'(mag >> DIV_PRE);
      sat_r[0] <= (mag >= lim);
      neg_r[0] <= neg;
      for (int k = 1; k < DIV_LAT-2; k++) begin
        x_r[k] <= x_r[k-1];
      end
      for (int k = 1; k < DIV_LAT-1; k++) begin
        sat_r[k] <= sat_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      // two 25x32 partial products; their sum is shifted into the registered estimate
      pp_hi_r <= PP_W'(x_r[0][X_W-1:XH_W]) * PP_W'(rcp);
      pp_lo_r <= PP_W'(x_r[0][XH_W-1:0]) * PP_W'(rcp);
      qe_r    <= Q_W'(pp_sum >> sh);
      // back-multiply the estimate for the remainder check
      qd_r    <= X_W'(qe_r) * X_W'(dvs);
      q4_r    <= qe_r;
    end
  end

  ppsc_div_cell u_fix (
    .clk    (clk),
    .en     (en),
    .rem_in (rem),
    .q_in   (q4_r),
    .dvs    (dvs),
    .q_out  (q5)
  );

  always_comb begin
    priority if (sat_r[DIV_LAT-2]) begin
      res_nxt = neg_r[DIV_LAT-2] ? {1'b1, (RES_W-1)'(0)} : {1'b0, {(RES_W-1){1'b1}}};
    end else if (neg_r[DIV_LAT-2]) begin
      res_nxt = RES_W'(0) - RES_W'(q5);
    end else begin
      res_nxt = RES_W'(q5);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> design/pluto_position_series_core.sv
// ----------------------------------------------------------------------------
// pluto_position_series_core - heliocentric position of pluto
// truncated periodic series in the mean anomaly, fixed point
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the skid entry is empty, fully pipelined, no item-to-item state
// the rate is set by the rows of horner cells and the division pipeline, each
// finishing one step per cycle; a two-entry output stage absorbs stalls
// reset: rst_n synchronous active low clears the valid bits only
module pluto_position_series_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] time_centuries
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // [31:0] longitude_deg, [63:32] latitude_deg,
                                  // [95:64] radius_au
);
  import ppsc_pkg::*;

  // whole pipeline advances together unless the skid entry is occupied
  logic en;
  logic [PIPE_LAT-1:0] vld_r;

  // stage 1: phase and longitude rate products
  logic signed [31:0]     t;
  logic signed [63:0]     ph_prod;
  logic signed [63:0]     tl_prod;
  logic [PH_W-1:0]        ph_raw_r;
  logic signed [TL_W-1:0] tl_r [TL_DLY];

  // stage 2: three phases
  logic [PH_W-1:0] p1, p2;
  logic [PH_W-1:0] ph_r [3];

  // trig lanes
  logic signed [TRIG_W-1:0] trig [NTRIG];

  // series products and sums
  logic signed [PROD_W-1:0] prod_r [NOUT][NTRIG];
  logic signed [NUM_W-1:0]  h0_r [NOUT];
  logic signed [NUM_W-1:0]  h1_r [NOUT];
  logic signed [NUM_W-1:0]  num_r [NOUT];
  logic [NUM_W-1:0]         mag_r [NOUT];
  logic                     neg_r [NOUT];
  logic [RES_W-1:0]         res [NOUT];

  // output register and skid
  logic        out_v_r, sk_v_r;
  logic [95:0] out_d_r, sk_d_r;
  logic [95:0] fin_d;
  logic        take;

  assign en        = !sk_v_r;
  assign in_tready = en;

  always_comb begin
    t       = signed'(in_tdata);
    ph_prod = 64'(t) * 64'(PH_RATE);
    tl_prod = 64'(t) * 64'(LON_RATE);
    p1      = ph_raw_r + PH_OFF;
    p2      = {p1[PH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_raw_r <= ph_prod[59:28];
      tl_r[0]  <= TL_W'(tl_prod);
      for (int k = 1; k < TL_DLY; k++) begin
        tl_r[k] <= tl_r[k-1];
      end
      ph_r[0] <= p1;
      ph_r[1] <= p2;
      ph_r[2] <= p1 + p2;
    end
  end

  // sine and cosine of p, 2p and 3p
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ppsc_sincos_lane u_lane (
      .clk (clk),
      .en  (en),
      .ph  (ph_r[i]),
      .sn  (trig[2*i]),
      .cs  (trig[2*i+1])
    );
  end

  // weighted sums, numerator and magnitude for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int o = 0; o < NOUT; o++) begin
        for (int j = 0; j < NTRIG; j++) begin
          prod_r[o][j] <= PROD_W'(trig[j]) * PROD_W'(SER_K[o][j]);
        end
        h0_r[o] <= NUM_W'(prod_r[o][0]) + NUM_W'(prod_r[o][1]) + NUM_W'(prod_r[o][2]);
        h1_r[o] <= NUM_W'(prod_r[o][3]) + NUM_W'(prod_r[o][4]) + NUM_W'(prod_r[o][5])
                 + SER_OFF[o] + ((o == 0) ? NUM_W'(tl_r[TL_DLY-1]) : NUM_W'(0));
        num_r[o] <= h0_r[o] + h1_r[o];
        neg_r[o] <= num_r[o][NUM_W-1];
        mag_r[o] <= (num_r[o][NUM_W-1] ? NUM_W'(-num_r[o]) : NUM_W'(num_r[o]))
                  + NUM_W'(SER_DEN[o] >> 1);
      end
    end
  end

  for (genvar o = 0; o < NOUT; o++) begin : g_div
    ppsc_div_lane u_div (
      .clk (clk),
      .en  (en),
      .mag (mag_r[o]),
      .neg (neg_r[o]),
      .dvs (DIV_DVS[o]),
      .rcp (DIV_RCP[o]),
      .sh  (DIV_SH[o]),
      .res (res[o])
    );
  end

  // valid bits follow the data down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  assign fin_d = {res[2], res[1], res[0]};
  assign take  = en && vld_r[PIPE_LAT-1];

  // output beat register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      priority if (out_v_r && !out_tready) begin
        if (take) begin
          sk_v_r <= 1'b1;
          sk_d_r <= fin_d;
        end
      end else if (sk_v_r) begin
        out_v_r <= 1'b1;
        out_d_r <= sk_d_r;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= take;
        out_d_r <= fin_d;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

>>> design/ppsc_port_chk.sv
// ----------------------------------------------------------------------------
// ppsc_port_chk - port-level checks for the pluto position series core
// watches the stream handshakes of the top level
// ----------------------------------------------------------------------------
module ppsc_port_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");

  // input backpressure only while a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // once the waiting result drains, input opens again
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("input stayed stalled after output drained");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind pluto_position_series_core ppsc_port_chk u_port_chk (.*);
